// ----- design/fwrv_pkg.sv -----
// ----------------------------------------------------------------------------
// fwrv_pkg
// Shared types, codes, constants and the byte-wide CRC-32 for the firmware
// image receive and verify block.
// ----------------------------------------------------------------------------
package fwrv_pkg;

    localparam int STAGE_BYTES = 131072;

    localparam int LEN_W   = 18;
    localparam int CRC_W   = 32;
    localparam int TICK_W  = 16;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;
    localparam int STAGE_W = 21;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] SRAM_LO    = 32'h2000_0000;
    localparam logic [WORD_W-1:0] SRAM_HI    = 32'h2004_0000;
    localparam logic [WORD_W-1:0] FLASH_LO   = 32'h0800_0000;
    localparam logic [WORD_W-1:0] FLASH_END  = 32'h0808_0000;
    localparam logic [LEN_W-1:0]  VEC_BYTES  = 18'd8;

    localparam logic [LEN_W-1:0]  RST_IMAGE_LENGTH = 18'd0;
    localparam logic [CRC_W-1:0]  RST_EXPECTED_CRC = 32'd0;
    localparam logic [LEN_W-1:0]  RST_MIN_SIZE     = 18'd8;
    localparam logic [TICK_W-1:0] RST_RX_TIMEOUT   = 16'd5000;
    localparam logic [TICK_W-1:0] RST_PROG_DELAY   = 16'd500;

    localparam logic [2:0] REG_IMAGE_LENGTH = 3'd0;
    localparam logic [2:0] REG_EXPECTED_CRC = 3'd1;
    localparam logic [2:0] REG_MIN_SIZE     = 3'd2;
    localparam logic [2:0] REG_RX_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_PROG_DELAY   = 3'd4;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RECV  = 2'd1,
        PH_ARMED = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_NONE       = 4'd0,
        ST_READY      = 4'd1,
        ST_BUSY       = 4'd2,
        ST_SIZE_BAD   = 4'd3,
        ST_ACCEPTED   = 4'd4,
        ST_TIMEOUT    = 4'd5,
        ST_CRC_BAD    = 4'd6,
        ST_VECTOR_BAD = 4'd7,
        ST_ARMED      = 4'd8,
        ST_FIRE       = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        FLT_SHORT = 2'd0,
        FLT_STACK = 2'd1,
        FLT_ENTRY = 2'd2,
        FLT_THUMB = 2'd3
    } fault_t;

    typedef struct packed {
        logic [LEN_W-1:0]  image_length;
        logic [CRC_W-1:0]  expected_crc;
        logic [LEN_W-1:0]  min_image_size;
        logic [TICK_W-1:0] rx_timeout_ticks;
        logic [TICK_W-1:0] program_delay_ticks;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        fault_t           vector_fault;
        logic [LEN_W-1:0] received_count;
        logic [CRC_W-1:0] computed_crc;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                   input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/firmware_image_receive_verify_core.sv -----
// ----------------------------------------------------------------------------
// firmware_image_receive_verify_core
// Receives a firmware image byte stream, checks its CRC-32 and vector table,
// and times the receive and the program delay.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   action, data_byte
//   out       out_valid / out_stall status, vector_fault, received_count,
//                                   computed_crc
//   config    APB psel/penable      paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while out is not stalled; a transaction
// passes the input register, then the result register. The rate is set by the
// byte-wide CRC and the verify compares, computed combinationally between them.
// Reset clears the update state and loads the register defaults.
// A stall on out holds the result register, which backs up the input
// register and raises in_stall.
// ----------------------------------------------------------------------------
module firmware_image_receive_verify_core
    import fwrv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         status,
    output logic [1:0]         vector_fault,
    output logic [LEN_W-1:0]   received_count,
    output logic [CRC_W-1:0]   computed_crc,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t       cfg;
    result_t    step_res;
    result_t    res_reg;
    logic       hold_vld_reg, hold_vld_next;
    logic       out_vld_reg, out_vld_next;
    logic [1:0] act_reg;
    logic [7:0] byte_reg;
    logic       advance;
    logic       accept;

    fwrv_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fwrv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .action    (act_reg),
        .data_byte (byte_reg),
        .cfg       (cfg),
        .res       (step_res)
    );

    assign advance  = hold_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = hold_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb begin
        hold_vld_next = hold_vld_reg;
        if (accept) hold_vld_next = 1'b1;
        else if (advance) hold_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance) out_vld_next = 1'b1;
        else if (!out_stall) out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            act_reg  <= action;
            byte_reg <= data_byte;
        end
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign out_valid      = out_vld_reg;
    assign status         = res_reg.status;
    assign vector_fault   = res_reg.vector_fault;
    assign received_count = res_reg.received_count;
    assign computed_crc   = res_reg.computed_crc;

endmodule

// ----- design/fwrv_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fwrv_cfg_regs
// APB register file holding the update configuration.
// ----------------------------------------------------------------------------
module fwrv_cfg_regs
    import fwrv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.image_length        <= RST_IMAGE_LENGTH;
            cfg_reg.expected_crc        <= RST_EXPECTED_CRC;
            cfg_reg.min_image_size      <= RST_MIN_SIZE;
            cfg_reg.rx_timeout_ticks    <= RST_RX_TIMEOUT;
            cfg_reg.program_delay_ticks <= RST_PROG_DELAY;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_LENGTH: cfg_reg.image_length        <= pwdata[LEN_W-1:0];
                REG_EXPECTED_CRC: cfg_reg.expected_crc        <= pwdata[CRC_W-1:0];
                REG_MIN_SIZE:     cfg_reg.min_image_size      <= pwdata[LEN_W-1:0];
                REG_RX_TIMEOUT:   cfg_reg.rx_timeout_ticks    <= pwdata[TICK_W-1:0];
                REG_PROG_DELAY:   cfg_reg.program_delay_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_LENGTH: prdata = {14'd0, cfg_reg.image_length};
            REG_EXPECTED_CRC: prdata = cfg_reg.expected_crc;
            REG_MIN_SIZE:     prdata = {14'd0, cfg_reg.min_image_size};
            REG_RX_TIMEOUT:   prdata = {16'd0, cfg_reg.rx_timeout_ticks};
            REG_PROG_DELAY:   prdata = {16'd0, cfg_reg.program_delay_ticks};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- design/fwrv_core.sv -----
// ----------------------------------------------------------------------------
// fwrv_core
// Update state, running CRC, vector capture and verify for one transaction
// per cycle while step_en is high.
// ----------------------------------------------------------------------------
module fwrv_core
    import fwrv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [1:0] action,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic [WORD_W-1:0]   stack_reg, stack_next;
    logic [WORD_W-1:0]   entry_reg, entry_next;

    logic                len_bad;
    logic                in_recv;
    logic                take;
    logic [LEN_W-1:0]    count_taken;
    logic [CRC_W-1:0]    crc_taken;
    logic [WORD_W-1:0]   stack_taken;
    logic [WORD_W-1:0]   entry_taken;
    logic [WORD_W-1:0]   lane_word;
    logic                done;
    logic                crc_ok;
    logic                vec_ok;
    fault_t              vec_fault;
    logic [TICK_W:0]     tick_inc;
    logic                timeout;
    logic                fire;

    always_comb begin
        len_bad = (cfg.image_length < cfg.min_image_size) ||
                  ({3'd0, cfg.image_length} > STAGE_W'(STAGE_BYTES));
        in_recv = (phase_reg == PH_RECV);
        take    = in_recv && (byte_count_reg < cfg.image_length);

        lane_word   = {24'd0, data_byte} << {byte_count_reg[1:0], 3'b000};
        count_taken = take ? (byte_count_reg + 18'd1) : byte_count_reg;
        crc_taken   = take ? crc_byte(crc_reg, data_byte) : crc_reg;
        stack_taken = (take && byte_count_reg[LEN_W-1:2] == 16'd0) ?
                      (stack_reg | lane_word) : stack_reg;
        entry_taken = (take && byte_count_reg[LEN_W-1:2] == 16'd1) ?
                      (entry_reg | lane_word) : entry_reg;

        done   = count_taken >= cfg.image_length;
        crc_ok = (crc_taken ^ ALL_ONES) == cfg.expected_crc;

        vec_ok    = 1'b0;
        vec_fault = FLT_SHORT;
        if (cfg.image_length < VEC_BYTES) begin
            vec_fault = FLT_SHORT;
        end else if (stack_taken < SRAM_LO || stack_taken > SRAM_HI) begin
            vec_fault = FLT_STACK;
        end else if (entry_taken < FLASH_LO || entry_taken >= FLASH_END) begin
            vec_fault = FLT_ENTRY;
        end else if (!entry_taken[0]) begin
            vec_fault = FLT_THUMB;
        end else begin
            vec_ok = 1'b1;
        end

        tick_inc = {1'b0, elapsed_reg} + 17'd1;
        timeout  = tick_inc > {1'b0, cfg.rx_timeout_ticks};
        fire     = tick_inc >= {1'b0, cfg.program_delay_ticks};
    end

    always_comb begin
        phase_next = phase_reg;
        case (action)
            ACT_START: begin
                if (phase_reg == PH_IDLE && !len_bad) phase_next = PH_RECV;
            end
            ACT_BYTE: begin
                if (in_recv && done) phase_next = (crc_ok && vec_ok) ? PH_ARMED : PH_IDLE;
            end
            ACT_TICK: begin
                if (in_recv && timeout) phase_next = PH_IDLE;
                else if (phase_reg == PH_ARMED && fire) phase_next = PH_IDLE;
            end
            default: ;
        endcase
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        elapsed_next     = elapsed_reg;
        stack_next       = stack_reg;
        entry_next       = entry_reg;
        res.status       = ST_NONE;
        res.vector_fault = FLT_SHORT;
        case (action)
            ACT_START: begin
                if (phase_reg != PH_IDLE) begin
                    res.status = ST_BUSY;
                end else if (len_bad) begin
                    res.status = ST_SIZE_BAD;
                end else begin
                    byte_count_next = '0;
                    crc_next        = ALL_ONES;
                    elapsed_next    = '0;
                    stack_next      = '0;
                    entry_next      = '0;
                    res.status      = ST_READY;
                end
            end
            ACT_BYTE: begin
                if (in_recv) begin
                    byte_count_next = count_taken;
                    crc_next        = crc_taken;
                    stack_next      = stack_taken;
                    entry_next      = entry_taken;
                    elapsed_next    = '0;
                    res.status      = ST_ACCEPTED;
                    if (done) begin
                        if (!crc_ok) begin
                            res.status = ST_CRC_BAD;
                        end else if (!vec_ok) begin
                            res.status       = ST_VECTOR_BAD;
                            res.vector_fault = vec_fault;
                        end else begin
                            res.status = ST_ARMED;
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (in_recv) begin
                    if (timeout) res.status = ST_TIMEOUT;
                    else elapsed_next = tick_inc[TICK_W-1:0];
                end else if (phase_reg == PH_ARMED) begin
                    if (fire) res.status = ST_FIRE;
                    else elapsed_next = tick_inc[TICK_W-1:0];
                end
            end
            default: ;
        endcase
        res.received_count = byte_count_next;
        res.computed_crc   = crc_next ^ ALL_ONES;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            crc_reg        <= ALL_ONES;
            elapsed_reg    <= '0;
            stack_reg      <= '0;
            entry_reg      <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            elapsed_reg    <= elapsed_next;
            stack_reg      <= stack_next;
            entry_reg      <= entry_next;
        end
    end

    a_armed_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.status == ST_ARMED |=> phase_reg == PH_ARMED)
        else $error("armed result without armed phase");

    a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (res.status == ST_FIRE || res.status == ST_TIMEOUT)
        |=> phase_reg == PH_IDLE)
        else $error("fire or timeout did not return to idle");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(byte_count_reg) && $stable(crc_reg) && $stable(phase_reg))
        else $error("update state changed without a transaction");

    a_fault_only_vector: assert property (@(posedge clk) disable iff (!rst_n)
        res.vector_fault != FLT_SHORT |-> res.status == ST_VECTOR_BAD)
        else $error("vector fault reported with another status");

endmodule
